// ----- rtl/bnms_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bnms_pkg
// Shared constants and types of the box non-maximum suppression block.
// ---------------------------------------------------------------------------
package bnms_pkg;

	localparam int MAX_BOXES = 64;
	localparam int IDX_W     = $clog2(MAX_BOXES);
	localparam int CNT_W     = $clog2(MAX_BOXES + 1);
	localparam int THR_W     = 17;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;

	localparam logic [THR_W-1:0]  THR_RESET     = 17'd32768;
	localparam logic signed [15:0] DISCARD_RESET = -16'sd7066;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_SOFT      = 2'd1,
		CFG_DISCARD   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] score;
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic signed [15:0] right;
		logic signed [15:0] bottom;
		logic [23:0]        tag;
		logic               final_box;
	} box_in_t;

	typedef struct packed {
		logic signed [15:0] kept_score;
		logic signed [15:0] kept_left;
		logic signed [15:0] kept_top;
		logic signed [15:0] kept_right;
		logic signed [15:0] kept_bottom;
		logic [23:0]        kept_tag;
		logic               end_of_set;
	} kept_t;

	typedef struct packed {
		logic signed [15:0] score;
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic signed [15:0] right;
		logic signed [15:0] bottom;
		logic [23:0]        tag;
	} box_t;

	typedef struct packed {
		logic             alive;
		logic [IDX_W-1:0] idx;
		box_t             box;
	} cell_t;

	typedef struct packed {
		logic               over;
		logic signed [15:0] new_score;
	} pair_res_t;

endpackage

// ----- rtl/bnms_box_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bnms_box_if
// Input box channel: valid, ready and one box per beat.
// ---------------------------------------------------------------------------
interface bnms_box_if;
	logic              valid;
	logic              ready;
	bnms_pkg::box_in_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/bnms_kept_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bnms_kept_if
// Result channel: valid, ready and one kept box per beat.
// ---------------------------------------------------------------------------
interface bnms_kept_if;
	logic            valid;
	logic            ready;
	bnms_pkg::kept_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/bnms_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bnms_cell
// One ring cell: holds a box, its load index and its alive flag.
// ---------------------------------------------------------------------------
module bnms_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load_en,
	input  bnms_pkg::cell_t load_data,
	input  logic            shift_en,
	input  bnms_pkg::cell_t shift_data,
	input  logic            clear,
	output bnms_pkg::cell_t contents
);

	logic                       alive_q;
	logic [bnms_pkg::IDX_W-1:0] idx_q;
	bnms_pkg::box_t             box_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b0;
		end else if (clear) begin
			alive_q <= 1'b0;
		end else if (load_en) begin
			alive_q <= load_data.alive;
		end else if (shift_en) begin
			alive_q <= shift_data.alive;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			idx_q <= load_data.idx;
			box_q <= load_data.box;
		end else if (shift_en) begin
			idx_q <= shift_data.idx;
			box_q <= shift_data.box;
		end
	end

	assign contents.alive = alive_q;
	assign contents.idx   = idx_q;
	assign contents.box   = box_q;

endmodule

// ----- rtl/bnms_pair.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bnms_pair
// Pair unit: IoU of two boxes by bit-serial division, then the threshold
// test or the Gaussian log-domain penalty on the second box's score.
// ---------------------------------------------------------------------------
module bnms_pair (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  bnms_pkg::box_t             a,
	input  bnms_pkg::box_t             b,
	input  logic [bnms_pkg::THR_W-1:0] thr,
	input  logic                       soft_en,
	output logic                       done,
	output bnms_pkg::pair_res_t        res
);

	typedef enum logic [2:0] {
		P_IDLE, P_MUL, P_UNI, P_DIVI, P_POST, P_SQ, P_DIVP, P_FIN
	} pstate_t;

	pstate_t            state_q;
	logic [15:0]        dx_q, dy_q;
	logic signed [16:0] wa_q, ha_q, wb_q, hb_q;
	logic signed [15:0] sb_q;
	logic [31:0]        inter_q;
	logic signed [33:0] area_a_q, area_b_q;
	logic [47:0]        rem_q;
	logic [51:0]        dvs_q;
	logic [26:0]        quo_q;
	logic [4:0]         cnt_q;
	logic [32:0]        sq_q;

	logic signed [15:0] x0m, y0m, x1m, y1m;
	logic signed [16:0] dx_w, dy_w;
	logic signed [35:0] inter_x, uni_c;
	logic               ge;
	logic [16:0]        iou;
	logic signed [28:0] diff;

	always_comb begin
		x0m     = (a.left > b.left) ? a.left : b.left;
		y0m     = (a.top > b.top) ? a.top : b.top;
		x1m     = (a.right < b.right) ? a.right : b.right;
		y1m     = (a.bottom < b.bottom) ? a.bottom : b.bottom;
		dx_w    = $signed({x1m[15], x1m}) - $signed({x0m[15], x0m});
		dy_w    = $signed({y1m[15], y1m}) - $signed({y0m[15], y0m});
		inter_x = $signed({4'b0, inter_q});
		uni_c   = 36'(area_a_q) + 36'(area_b_q) - inter_x;
		ge      = {4'b0, rem_q} >= dvs_q;
		iou     = quo_q[16:0];
		diff    = 29'(sb_q) - $signed({2'b0, quo_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				P_IDLE: begin
					if (start) begin
						dx_q    <= dx_w[16] ? 16'd0 : dx_w[15:0];
						dy_q    <= dy_w[16] ? 16'd0 : dy_w[15:0];
						wa_q    <= $signed({a.right[15], a.right}) - $signed({a.left[15], a.left});
						ha_q    <= $signed({a.bottom[15], a.bottom}) - $signed({a.top[15], a.top});
						wb_q    <= $signed({b.right[15], b.right}) - $signed({b.left[15], b.left});
						hb_q    <= $signed({b.bottom[15], b.bottom}) - $signed({b.top[15], b.top});
						sb_q    <= b.score;
						state_q <= P_MUL;
					end
				end
				P_MUL: begin
					inter_q  <= 32'(dx_q) * 32'(dy_q);
					area_a_q <= 34'(wa_q) * 34'(ha_q);
					area_b_q <= 34'(wb_q) * 34'(hb_q);
					state_q  <= P_UNI;
				end
				P_UNI: begin
					quo_q <= '0;
					if (inter_q == 32'd0 || uni_c[35] || uni_c == 36'sd0) begin
						state_q <= P_POST;
					end else begin
						rem_q   <= {inter_q, 16'b0};
						dvs_q   <= {uni_c, 16'b0};
						cnt_q   <= 5'd16;
						state_q <= P_DIVI;
					end
				end
				P_DIVI: begin
					if (ge) begin
						rem_q <= rem_q - dvs_q[47:0];
					end
					quo_q <= {quo_q[25:0], ge};
					dvs_q <= dvs_q >> 1;
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= P_POST;
					end
				end
				P_POST: begin
					if (soft_en) begin
						sq_q    <= 33'(iou) * 33'(iou);
						state_q <= P_SQ;
					end else begin
						res.over      <= iou > thr;
						res.new_score <= sb_q;
						done          <= 1'b1;
						state_q       <= P_IDLE;
					end
				end
				P_SQ: begin
					rem_q   <= {15'b0, sq_q};
					dvs_q   <= {3'b0, thr, 32'b0};
					quo_q   <= '0;
					cnt_q   <= 5'd26;
					state_q <= P_DIVP;
				end
				P_DIVP: begin
					if (ge) begin
						rem_q <= rem_q - dvs_q[47:0];
					end
					quo_q <= {quo_q[25:0], ge};
					dvs_q <= dvs_q >> 1;
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= P_FIN;
					end
				end
				P_FIN: begin
					res.over      <= 1'b0;
					res.new_score <= (diff < -29'sd32768) ? -16'sd32768 : diff[15:0];
					done          <= 1'b1;
					state_q       <= P_IDLE;
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/box_non_max_suppression.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// box_non_max_suppression
// Non-maximum suppression over one set of boxes (hard or Gaussian soft),
// boxes held in a rotating ring of cells, one shared pair unit.
// ---------------------------------------------------------------------------
//  channel   dir  handshake          beat
//  boxes     in   valid/ready        one box, final_box closes the set
//  kept      out  valid/ready        one kept box, end_of_set on the last
//  cfg       in   cfg_we             register write, index and data
//
//  Loading: boxes are taken whenever the block is in its load state. Closing
//  a set (ring of MAX_BOXES cells): hard mode tests each stored box against
//  the higher-scored boxes; soft mode repeatedly keeps the best live box and
//  penalises the rest. The pair unit's serial dividers set the pair cost.
//  No clearing pass after reset. Result stalls hold the sequencer.
// ---------------------------------------------------------------------------
module box_non_max_suppression (
	input  logic                           clk,
	input  logic                           arst_n,
	bnms_box_if.sink                       boxes,
	bnms_kept_if.source                    kept,
	input  logic                           cfg_we,
	input  logic [bnms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bnms_pkg::CFG_W-1:0]     cfg_data
);

	localparam int N  = bnms_pkg::MAX_BOXES;
	localparam int IW = bnms_pkg::IDX_W;
	localparam int CW = bnms_pkg::CNT_W;

	typedef enum logic [3:0] {
		S_LOAD, S_START, S_H_REF, S_H_SCAN, S_H_WAIT, S_H_DEC, S_H_NEXT,
		S_S_FIND, S_S_PICK, S_S_PEN, S_S_WAIT, S_FIN, S_CLEAN
	} state_t;

	state_t                      state_q;
	logic [CW-1:0]               count_q, rot_q;
	logic [IW-1:0]               outer_q, best_idx_q;
	logic                        found_q, keep_q;
	bnms_pkg::box_t              ref_q, pend_q;
	logic                        pend_valid_q;
	bnms_pkg::kept_t             out_q;
	logic                        out_valid_q;
	logic [bnms_pkg::THR_W-1:0]  thr_q;
	logic                        soft_q;
	logic signed [15:0]          discard_q;

	bnms_pkg::cell_t             cell_out [N];
	bnms_pkg::cell_t             head, head_wb, new_cell;
	logic [N-1:0]                load_sel;
	logic                        in_beat, out_beat, load_en, rot_en, clr_en;
	logic                        pair_start, pair_done, push, fin_push, can_push;
	logic                        pass_all, better;
	bnms_pkg::pair_res_t         pair_res;

	function automatic bnms_pkg::kept_t to_kept(bnms_pkg::box_t bx, logic last);
		bnms_pkg::kept_t k;
		k.kept_score  = bx.score;
		k.kept_left   = bx.left;
		k.kept_top    = bx.top;
		k.kept_right  = bx.right;
		k.kept_bottom = bx.bottom;
		k.kept_tag    = bx.tag;
		k.end_of_set  = last;
		return k;
	endfunction

	assign boxes.ready   = (state_q == S_LOAD);
	assign kept.valid    = out_valid_q;
	assign kept.payload  = out_q;
	assign in_beat       = boxes.valid && boxes.ready;
	assign out_beat      = kept.valid && kept.ready;
	assign load_en       = in_beat && (count_q < CW'(N));
	assign clr_en        = (state_q == S_CLEAN);
	assign head          = cell_out[0];
	assign pass_all      = (thr_q == '0) || thr_q[bnms_pkg::THR_W-1];
	assign can_push      = !pend_valid_q || !out_valid_q || kept.ready;
	assign fin_push      = (state_q == S_FIN) && pend_valid_q && (!out_valid_q || kept.ready);

	always_comb begin
		new_cell.alive      = 1'b1;
		new_cell.idx        = count_q[IW-1:0];
		new_cell.box.score  = boxes.payload.score;
		new_cell.box.left   = boxes.payload.left;
		new_cell.box.top    = boxes.payload.top;
		new_cell.box.right  = boxes.payload.right;
		new_cell.box.bottom = boxes.payload.bottom;
		new_cell.box.tag    = boxes.payload.tag;
		for (int k = 0; k < N; k++) begin
			load_sel[k] = load_en && (count_q[IW-1:0] == IW'(k));
		end
		better = !found_q || (head.box.score > ref_q.score) ||
			((head.box.score == ref_q.score) && (head.idx < best_idx_q));
	end

	always_comb begin
		rot_en     = 1'b0;
		head_wb    = head;
		pair_start = 1'b0;
		push       = 1'b0;
		unique case (state_q)
			S_H_SCAN: begin
				if (rot_q != CW'(N)) begin
					if (head.alive && keep_q && (ref_q.score < head.box.score)) begin
						pair_start = 1'b1;
					end else begin
						rot_en = 1'b1;
					end
				end
			end
			S_H_WAIT: rot_en = pair_done;
			S_H_DEC:  push = keep_q && can_push;
			S_H_NEXT: rot_en = 1'b1;
			S_S_FIND: rot_en = (rot_q != CW'(N));
			S_S_PICK: push = found_q && can_push;
			S_S_PEN: begin
				if (rot_q != CW'(N)) begin
					if (head.alive && head.idx == best_idx_q) begin
						head_wb.alive = 1'b0;
						rot_en        = 1'b1;
					end else if (head.alive) begin
						pair_start = 1'b1;
					end else begin
						rot_en = 1'b1;
					end
				end
			end
			S_S_WAIT: begin
				if (pair_done) begin
					head_wb.box.score = pair_res.new_score;
					head_wb.alive     = !(pair_res.new_score < discard_q);
					rot_en            = 1'b1;
				end
			end
			default: ;
		endcase
	end

	for (genvar k = 0; k < N; k++) begin : g_ring
		bnms_pkg::cell_t next_in;
		if (k == N - 1) begin : g_tail
			assign next_in = head_wb;
		end else begin : g_body
			assign next_in = cell_out[k+1];
		end
		bnms_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.load_en    (load_sel[k]),
			.load_data  (new_cell),
			.shift_en   (rot_en),
			.shift_data (next_in),
			.clear      (clr_en),
			.contents   (cell_out[k])
		);
	end

	bnms_pair u_pair (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (pair_start),
		.a       (ref_q),
		.b       (head.box),
		.thr     (thr_q),
		.soft_en (soft_q),
		.done    (pair_done),
		.res     (pair_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= bnms_pkg::THR_RESET;
			soft_q    <= 1'b0;
			discard_q <= bnms_pkg::DISCARD_RESET;
		end else if (cfg_we) begin
			unique case (bnms_pkg::cfg_reg_t'(cfg_index))
				bnms_pkg::CFG_THRESHOLD: thr_q     <= cfg_data[bnms_pkg::THR_W-1:0];
				bnms_pkg::CFG_SOFT:      soft_q    <= cfg_data[0];
				bnms_pkg::CFG_DISCARD:   discard_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			count_q      <= '0;
			rot_q        <= '0;
			outer_q      <= '0;
			best_idx_q   <= '0;
			found_q      <= 1'b0;
			keep_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push) begin
				if (pend_valid_q) begin
					out_q       <= to_kept(pend_q, 1'b0);
					out_valid_q <= 1'b1;
				end else if (out_beat) begin
					out_valid_q <= 1'b0;
				end
				pend_q       <= ref_q;
				pend_valid_q <= 1'b1;
			end else if (fin_push) begin
				out_q        <= to_kept(pend_q, 1'b1);
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (out_beat) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_LOAD: begin
					if (in_beat) begin
						if (load_en) begin
							count_q <= count_q + CW'(1);
						end
						if (boxes.payload.final_box) begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					rot_q   <= '0;
					outer_q <= '0;
					found_q <= 1'b0;
					if (count_q == '0) begin
						state_q <= S_CLEAN;
					end else if (pass_all || !soft_q) begin
						state_q <= S_H_REF;
					end else begin
						state_q <= S_S_FIND;
					end
				end
				S_H_REF: begin
					if (head.alive) begin
						ref_q   <= head.box;
						keep_q  <= 1'b1;
						rot_q   <= '0;
						state_q <= pass_all ? S_H_DEC : S_H_SCAN;
					end else begin
						state_q <= S_H_NEXT;
					end
				end
				S_H_SCAN: begin
					if (rot_q == CW'(N)) begin
						state_q <= S_H_DEC;
					end else if (pair_start) begin
						state_q <= S_H_WAIT;
					end else begin
						rot_q <= rot_q + CW'(1);
					end
				end
				S_H_WAIT: begin
					if (pair_done) begin
						if (pair_res.over) begin
							keep_q <= 1'b0;
						end
						rot_q   <= rot_q + CW'(1);
						state_q <= S_H_SCAN;
					end
				end
				S_H_DEC: begin
					if (!keep_q || push) begin
						state_q <= S_H_NEXT;
					end
				end
				S_H_NEXT: begin
					if (outer_q == IW'(N - 1)) begin
						state_q <= S_FIN;
					end else begin
						outer_q <= outer_q + IW'(1);
						state_q <= S_H_REF;
					end
				end
				S_S_FIND: begin
					if (rot_q != CW'(N)) begin
						rot_q <= rot_q + CW'(1);
						if (head.alive && better) begin
							ref_q      <= head.box;
							best_idx_q <= head.idx;
							found_q    <= 1'b1;
						end
					end else begin
						state_q <= S_S_PICK;
					end
				end
				S_S_PICK: begin
					if (!found_q) begin
						state_q <= S_FIN;
					end else if (push) begin
						rot_q   <= '0;
						state_q <= S_S_PEN;
					end
				end
				S_S_PEN: begin
					if (rot_q == CW'(N)) begin
						rot_q   <= '0;
						found_q <= 1'b0;
						state_q <= S_S_FIND;
					end else if (pair_start) begin
						state_q <= S_S_WAIT;
					end else begin
						rot_q <= rot_q + CW'(1);
					end
				end
				S_S_WAIT: begin
					if (pair_done) begin
						rot_q   <= rot_q + CW'(1);
						state_q <= S_S_PEN;
					end
				end
				S_FIN: begin
					if (!pend_valid_q || fin_push) begin
						state_q <= S_CLEAN;
					end
				end
				S_CLEAN: begin
					count_q <= '0;
					state_q <= S_LOAD;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for box_non_max_suppression.
// Sets of boxes are streamed in with bursty valid, and results are drained
// with a stalling ready. An in-bench suppression model predicts each kept
// box, and every output beat is compared field by field in order. The run
// covers hard, soft and pass-through settings, full and overflowing stores,
// score ties, degenerate boxes and saturating decay.
// ---------------------------------------------------------------------------
module testbench;
	import bnms_pkg::*;

	localparam int WATCHDOG_LIMIT = 600000;
	localparam int SETTLE_CYCLES  = 400;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	bnms_box_if  box_ch ();
	bnms_kept_if kept_ch ();

	box_non_max_suppression DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.boxes     (box_ch.sink),
		.kept      (kept_ch.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// model copy of the registers and the box store
	logic [THR_W-1:0]   model_threshold;
	logic               nms_soft;
	logic signed [15:0] nms_discard;
	box_t               set_boxes [MAX_BOXES];
	int                 set_count;

	box_in_t pending_boxes [$];
	kept_t   kept_expected [$];

	int error_count;
	int boxes_taken;
	int kept_seen;
	int sets_closed;
	int idle_cycles;

	// sender and receiver behavior
	bit steady_send;
	int burst_left;
	int gap_left;
	int stall_kind;
	int stall_left;

	function automatic longint iou_of(box_t a, box_t b);
		longint x0a, y0a, x1a, y1a, x0b, y0b, x1b, y1b;
		longint dx, dy, inter, uni;
		x0a = a.left; y0a = a.top; x1a = a.right; y1a = a.bottom;
		x0b = b.left; y0b = b.top; x1b = b.right; y1b = b.bottom;
		dx = ((x1a < x1b) ? x1a : x1b) - ((x0a > x0b) ? x0a : x0b);
		dy = ((y1a < y1b) ? y1a : y1b) - ((y0a > y0b) ? y0a : y0b);
		if (dx < 0) dx = 0;
		if (dy < 0) dy = 0;
		inter = dx * dy;
		uni = (x1a - x0a) * (y1a - y0a) + (x1b - x0b) * (y1b - y0b) - inter;
		if (inter == 0 || uni <= 0)
			return 0;
		return (inter <<< 16) / uni;
	endfunction

	function automatic void push_kept(box_t b, logic signed [15:0] s);
		kept_t k;
		k.kept_score  = s;
		k.kept_left   = b.left;
		k.kept_top    = b.top;
		k.kept_right  = b.right;
		k.kept_bottom = b.bottom;
		k.kept_tag    = b.tag;
		k.end_of_set  = 1'b0;
		kept_expected = {kept_expected, k};
	endfunction

	function automatic void close_set();
		int     first;
		int     best;
		bit     keep;
		bit     alive [MAX_BOXES];
		longint cur [MAX_BOXES];
		longint iou, pen;
		first = kept_expected.size();
		if (model_threshold == 0 || model_threshold >= 17'd65536) begin
			for (int i = 0; i < set_count; i++)
				push_kept(set_boxes[i], set_boxes[i].score);
		end else if (!nms_soft) begin
			for (int i = 0; i < set_count; i++) begin
				keep = 1;
				for (int j = 0; j < set_count && keep; j++)
					if (set_boxes[i].score < set_boxes[j].score &&
					    iou_of(set_boxes[i], set_boxes[j]) > model_threshold)
						keep = 0;
				if (keep)
					push_kept(set_boxes[i], set_boxes[i].score);
			end
		end else begin
			for (int i = 0; i < set_count; i++) begin
				alive[i] = 1;
				cur[i]   = set_boxes[i].score;
			end
			forever begin
				best = -1;
				for (int i = 0; i < set_count; i++)
					if (alive[i] && (best < 0 || cur[i] > cur[best]))
						best = i;
				if (best < 0)
					break;
				alive[best] = 0;
				push_kept(set_boxes[best], cur[best][15:0]);
				for (int i = 0; i < set_count; i++) begin
					if (!alive[i])
						continue;
					iou = iou_of(set_boxes[best], set_boxes[i]);
					pen = (iou * iou) / (longint'(model_threshold) * 64);
					cur[i] = cur[i] - pen;
					if (cur[i] < -32768)
						cur[i] = -32768;
					if (cur[i] < nms_discard)
						alive[i] = 0;
				end
			end
		end
		if (kept_expected.size() > first)
			kept_expected[kept_expected.size() - 1].end_of_set = 1'b1;
		set_count = 0;
		sets_closed++;
	endfunction

	function automatic void take_box(box_in_t b);
		if (set_count < MAX_BOXES) begin
			set_boxes[set_count] = '{b.score, b.left, b.top, b.right, b.bottom, b.tag};
			set_count++;
		end
		if (b.final_box)
			close_set();
	endfunction

	function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		bit offer;
		if (!arst_n) begin
			box_ch.valid   <= 1'b0;
			box_ch.payload <= '0;
		end else begin
			offer = 0;
			if (box_ch.valid && box_ch.ready) begin
				take_box(box_ch.payload);
				void'(pending_boxes.pop_front());
				boxes_taken++;
			end
			if (box_ch.valid && !box_ch.ready) begin
				offer = 1;
			end else if (pending_boxes.size() > 0) begin
				if (steady_send) begin
					offer = 1;
				end else if (gap_left > 0) begin
					gap_left--;
				end else begin
					offer = 1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left   = $urandom_range(0, 6);
					end else begin
						burst_left--;
					end
				end
			end
			box_ch.valid <= offer;
			if (offer && pending_boxes.size() > 0)
				box_ch.payload <= pending_boxes[0];
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		kept_t want;
		kept_t got;
		if (!arst_n) begin
			kept_ch.ready <= 1'b0;
		end else begin
			if (kept_ch.valid && kept_ch.ready) begin
				got = kept_ch.payload;
				kept_seen++;
				if (kept_expected.size() == 0) begin
					$display("%0t: unexpected kept box, expected none, actual %h", $time, got);
					error_count++;
				end else begin
					want = kept_expected.pop_front();
					check_field("kept_score", 24'(want.kept_score), 24'(got.kept_score));
					check_field("kept_left", 24'(want.kept_left), 24'(got.kept_left));
					check_field("kept_top", 24'(want.kept_top), 24'(got.kept_top));
					check_field("kept_right", 24'(want.kept_right), 24'(got.kept_right));
					check_field("kept_bottom", 24'(want.kept_bottom),
					            24'(got.kept_bottom));
					check_field("kept_tag", want.kept_tag, got.kept_tag);
					check_field("end_of_set", 24'(want.end_of_set), 24'(got.end_of_set));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				kept_ch.ready <= 1'b0;
			end else if (stall_kind == 1 && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(0, 3);
				kept_ch.ready <= 1'b0;
			end else if (stall_kind == 2 && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(5, 25);
				kept_ch.ready <= 1'b0;
			end else begin
				kept_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((box_ch.valid && box_ch.ready) || (kept_ch.valid && kept_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, idle_cycles);
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			CFG_THRESHOLD: model_threshold = value[THR_W-1:0];
			CFG_SOFT:      nms_soft        = value[0];
			CFG_DISCARD:   nms_discard     = value[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_boxes.size() > 0 || kept_expected.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [THR_W-1:0] thr, bit soft_sel, logic signed [15:0] disc);
		wait_idle();
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_SOFT, {{(CFG_W-1){1'b0}}, soft_sel});
		write_reg(CFG_DISCARD, {{(CFG_W-16){disc[15]}}, disc});
	endtask

	function automatic box_in_t make_box(bit wild);
		box_in_t b;
		int cx, cy, w, h;
		b.score  = 16'($urandom);
		b.left   = 16'($urandom); b.top    = 16'($urandom);
		b.right  = 16'($urandom); b.bottom = 16'($urandom);
		b.tag    = 24'($urandom);
		if (!wild) begin
			cx = $urandom_range(0, 12000) - 6000;
			cy = $urandom_range(0, 12000) - 6000;
			w  = $urandom_range(1, 9000);
			h  = $urandom_range(1, 9000);
			b.left   = 16'(cx - w);
			b.right  = 16'(cx + w);
			b.top    = 16'(cy - h);
			b.bottom = 16'(cy + h);
			if ($urandom_range(0, 2) != 0)
				b.score = 16'(int'($urandom_range(0, 40)) * 64 - 1200);
		end
		b.final_box = 1'b0;
		return b;
	endfunction

	task automatic queue_set(int count, int wild_pct);
		box_in_t b;
		for (int i = 0; i < count; i++) begin
			b = make_box($urandom_range(0, 99) < wild_pct);
			b.final_box = (i == count - 1);
			pending_boxes = {pending_boxes, b};
		end
	endtask

	task automatic queue_box(int s, int l, int t, int r, int btm, int tg, bit fin);
		box_in_t b;
		b.score = 16'(s); b.left = 16'(l); b.top = 16'(t); b.right = 16'(r);
		b.bottom = 16'(btm); b.tag = 24'(tg); b.final_box = fin;
		pending_boxes = {pending_boxes, b};
	endtask

	task automatic directed_sets();
		// extremes, identical boxes with a score tie, a degenerate box
		queue_box(32767, -32768, -32768, 32767, 32767, 24'hFFFFFF, 0);
		queue_box(-32768, 32767, 32767, -32768, -32768, 24'h000000, 0);
		queue_box(1000, 0, 0, 8192, 8192, 24'h000011, 0);
		queue_box(1000, 0, 0, 8192, 8192, 24'h000012, 0);
		queue_box(2000, 100, 100, 8292, 8292, 24'h000013, 0);
		queue_box(500, 4000, 4000, 4000, 9000, 24'h000014, 1);
		// single-box set
		queue_box(-5, 1, 2, 3, 4, 24'h5A5A5A, 1);
	endtask

	initial begin
		logic [THR_W-1:0] thr_pick [8];
		logic signed [15:0] disc_pick [4];
		int kind;
		arst_n          = 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= CFG_THRESHOLD;
		cfg_data        <= '0;
		model_threshold = THR_RESET;
		nms_soft        = 1'b0;
		nms_discard     = DISCARD_RESET;
		set_count       = 0;
		error_count     = 0;
		boxes_taken     = 0;
		kept_seen       = 0;
		sets_closed     = 0;
		idle_cycles     = 0;
		steady_send     = 1;
		burst_left      = 0;
		gap_left        = 0;
		stall_kind      = 0;
		stall_left      = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings first, then each mode on the directed sets
		directed_sets();
		configure(17'd0, 1'b0, DISCARD_RESET);
		directed_sets();
		configure(17'h1FFFF, 1'b1, DISCARD_RESET);
		directed_sets();
		configure(17'd65536, 1'b0, DISCARD_RESET);
		directed_sets();
		configure(17'd1, 1'b1, -16'sd32768);
		directed_sets();
		configure(17'd40000, 1'b1, 16'sd32767);
		directed_sets();

		thr_pick  = '{17'd1, 17'd65535, 17'd32768, 17'd20000, 17'd45000, 17'd6000,
		              17'd0, 17'd65536};
		disc_pick = '{-16'sd32768, -16'sd7066, 16'sd0, 16'sd32767};
		for (int phase = 0; phase < 12; phase++) begin
			configure(thr_pick[3'($urandom_range(0, 7))], (phase % 2) == 1,
			          disc_pick[2'($urandom_range(0, 3))]);
			kind        = phase % 3;
			steady_send = (kind == 0);
			stall_kind  = kind;
			if (phase == 4) begin
				// overflowing store: last two boxes ignored, final still closes
				queue_set(66, 10);
			end else if (phase == 9) begin
				queue_set(64, 10);
			end else begin
				for (int s = 0; s < 5; s++)
					queue_set($urandom_range(2, 10), 15);
			end
		end
		wait_idle();

		$display("run covered %0d boxes in %0d sets, %0d kept boxes checked",
		         boxes_taken, sets_closed, kept_seen);
		$display("modes: pass-through, hard and soft, thresholds and discard levels at extremes");
		if (error_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
